// ===== rtl/core/qpx_pkg.sv =====
// ----------------------------------------------------------------------------
// qpx_pkg
// Shared types, constants and helpers for the query parameter extractor.
// ----------------------------------------------------------------------------
package qpx_pkg;

  localparam int MAX_CAPACITY = 256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_KEY_LENGTH = 2'd2,
    CFG_CAPACITY   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_VALUE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  // decoded bytes produced by one transaction, in order
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } emit_t;

  // all results caused by one input transaction
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            summary;
    logic            found;
    logic [7:0]      length;
  } bundle_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

  function automatic emit_t emit_push(input emit_t e, input logic [7:0] b);
    emit_t r;
    r = e;
    case (e.cnt)
      2'd0: begin
        r.bytes[0] = b;
        r.cnt = 2'd1;
      end
      2'd1: begin
        r.bytes[1] = b;
        r.cnt = 2'd2;
      end
      2'd2: begin
        r.bytes[2] = b;
        r.cnt = 2'd3;
      end
      default: r = e;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/qpx_front.sv =====
// ----------------------------------------------------------------------------
// qpx_front
// Configuration registers, pair matching and percent decoding; turns each
// input transaction into at most one bundle of results.
// ----------------------------------------------------------------------------
module qpx_front #(
  parameter int KEY_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        query_byte,
  input  logic              final_byte,
  input  logic              queue_full,
  output logic              push,
  output qpx_pkg::bundle_t  push_data
);
  import qpx_pkg::*;

  typedef enum logic [3:0] {
    PH_MATCH = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_IDLE  = 4'b1000
  } phase_t;

  logic [15:0][7:0]          key;
  logic [4:0]                key_length;
  logic [8:0]                value_capacity;

  phase_t     phase, phase_next;
  logic [4:0] match_index, match_index_next;
  logic [1:0] held_count, held_count_next;
  logic [7:0] held_digit, held_digit_next;
  logic [7:0] written_count;
  logic       found_flag, found_flag_next;

  logic [8:0] cap_eff;
  logic [7:0] limit;
  logic [7:0] room;
  logic [1:0] nemit;
  logic       usable;
  logic [7:0] key_byte;
  logic [4:0] hv;
  logic [4:0] hd_val;
  logic       is_pct;
  logic [7:0] plain_byte;
  emit_t      cand;
  logic       accept;

  always_comb begin
    cap_eff = (17'(value_capacity) > 17'(MAX_CAPACITY)) ? 9'(MAX_CAPACITY)
                                                        : value_capacity;
    limit   = (cap_eff == 9'd0) ? 8'd0 : 8'(cap_eff - 9'd1);
    usable  = (key_length != 5'd0) && (key_length <= 5'(KEY_BYTES)) &&
              (cap_eff != 9'd0);
    key_byte = key[match_index[3:0]];
  end

  always_comb begin
    hv               = hex_val(query_byte);
    hd_val           = hex_val(held_digit);
    is_pct           = query_byte == CH_PERCENT;
    plain_byte       = (query_byte == CH_PLUS) ? CH_SPACE : query_byte;
    cand             = '0;
    phase_next       = phase;
    match_index_next = match_index;
    held_count_next  = held_count;
    held_digit_next  = held_digit;
    found_flag_next  = found_flag;

    if (query_byte == CH_NUL) begin
      if (phase == PH_VALUE) begin
        if (held_count_next != 2'd0) cand = emit_push(cand, CH_PERCENT);
        if (held_count_next == 2'd2) cand = emit_push(cand, held_digit_next);
        held_count_next = 2'd0;
        held_digit_next = 8'd0;
      end
      phase_next = PH_IDLE;
    end else begin
      case (phase)
        PH_MATCH: begin
          if (query_byte == CH_AMP) begin
            match_index_next = 5'd0;
          end else if (!usable) begin
            phase_next = PH_SKIP;
          end else if (match_index < key_length) begin
            if (query_byte == key_byte) match_index_next = match_index + 5'd1;
            else phase_next = PH_SKIP;
          end else if (query_byte == CH_EQUALS) begin
            phase_next      = PH_VALUE;
            found_flag_next = 1'b1;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (query_byte == CH_AMP) begin
            phase_next       = PH_MATCH;
            match_index_next = 5'd0;
          end
        end
        PH_VALUE: begin
          if (query_byte == CH_AMP) begin
            if (held_count != 2'd0) cand = emit_push(cand, CH_PERCENT);
            if (held_count == 2'd2) cand = emit_push(cand, held_digit);
            held_count_next = 2'd0;
            held_digit_next = 8'd0;
            phase_next      = PH_IDLE;
          end else if (held_count == 2'd2) begin
            held_count_next = 2'd0;
            held_digit_next = 8'd0;
            if (!hv[4]) begin
              cand = emit_push(cand, {hd_val[3:0], hv[3:0]});
            end else begin
              cand = emit_push(cand, CH_PERCENT);
              cand = emit_push(cand, held_digit);
              if (is_pct) held_count_next = 2'd1;
              else cand = emit_push(cand, plain_byte);
            end
          end else if (held_count == 2'd1) begin
            if (!hv[4]) begin
              held_count_next = 2'd2;
              held_digit_next = query_byte;
            end else begin
              held_count_next = 2'd0;
              cand = emit_push(cand, CH_PERCENT);
              if (is_pct) held_count_next = 2'd1;
              else cand = emit_push(cand, plain_byte);
            end
          end else begin
            if (is_pct) held_count_next = 2'd1;
            else cand = emit_push(cand, plain_byte);
          end
        end
        PH_IDLE: begin
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (final_byte && phase_next == PH_VALUE) begin
      if (held_count_next != 2'd0) cand = emit_push(cand, CH_PERCENT);
      if (held_count_next == 2'd2) cand = emit_push(cand, held_digit_next);
      held_count_next = 2'd0;
      held_digit_next = 8'd0;
    end
  end

  always_comb begin
    room  = (limit > written_count) ? limit - written_count : 8'd0;
    nemit = (room < 8'(cand.cnt)) ? room[1:0] : cand.cnt;
    push_data.nbytes  = nemit;
    push_data.bytes   = cand.bytes;
    push_data.summary = final_byte;
    push_data.found   = found_flag_next;
    push_data.length  = written_count + 8'(nemit);
  end

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && ((nemit != 2'd0) || final_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      key            <= '0;
      key_length     <= 5'd0;
      value_capacity <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_KEY_LOW:    key[7:0]       <= cfg_data;
        CFG_KEY_HIGH:   key[15:8]      <= cfg_data;
        CFG_KEY_LENGTH: key_length     <= cfg_data[4:0];
        CFG_CAPACITY:   value_capacity <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MATCH;
      match_index   <= 5'd0;
      held_count    <= 2'd0;
      held_digit    <= 8'd0;
      written_count <= 8'd0;
      found_flag    <= 1'b0;
    end else if (accept) begin
      if (final_byte) begin
        phase         <= PH_MATCH;
        match_index   <= 5'd0;
        held_count    <= 2'd0;
        held_digit    <= 8'd0;
        written_count <= 8'd0;
        found_flag    <= 1'b0;
      end else begin
        phase         <= phase_next;
        match_index   <= match_index_next;
        held_count    <= held_count_next;
        held_digit    <= held_digit_next;
        written_count <= push_data.length;
        found_flag    <= found_flag_next;
      end
    end
  end

endmodule

// ===== rtl/core/qpx_queue.sv =====
// ----------------------------------------------------------------------------
// qpx_queue
// Short queue of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module qpx_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qpx_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output qpx_pkg::bundle_t  head_data
);
  import qpx_pkg::*;

  bundle_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wptr;
  logic [QUEUE_AW-1:0]    rptr;
  logic [QUEUE_CW-1:0]    count;

  assign full       = count == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/qpx_back.sv =====
// ----------------------------------------------------------------------------
// qpx_back
// Unpacks each bundle into single results and drives the output register.
// ----------------------------------------------------------------------------
module qpx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  qpx_pkg::bundle_t  head_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [7:0]        value_byte,
  output logic              found,
  output logic [7:0]        value_length,
  output logic              run_last
);
  import qpx_pkg::*;

  logic [1:0] idx;
  logic [2:0] total;
  logic       last;
  logic       is_summary;
  logic       load;
  logic [7:0] sel_byte;

  always_comb begin
    total      = 3'(head_data.nbytes) + 3'(head_data.summary);
    last       = (3'(idx) + 3'd1) == total;
    is_summary = idx == head_data.nbytes;
    case (idx)
      2'd0:    sel_byte = head_data.bytes[0];
      2'd1:    sel_byte = head_data.bytes[1];
      2'd2:    sel_byte = head_data.bytes[2];
      default: sel_byte = 8'd0;
    endcase
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind  <= is_summary ? KIND_SUMMARY : KIND_VALUE;
      value_byte   <= is_summary ? 8'd0 : sel_byte;
      found        <= is_summary && head_data.found;
      value_length <= is_summary ? head_data.length : 8'd0;
      run_last     <= last;
    end
  end

endmodule

// ===== rtl/core/query_parameter_extract_decode.sv =====
// ----------------------------------------------------------------------------
// query_parameter_extract_decode
// Selects one key=value pair from a query string and percent-decodes its value.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_write            cfg_index, cfg_data
//   in        in         in_valid / in_ready  query_byte, final_byte
//   out       out        out_valid / out_ready result_kind, value_byte, found,
//                                             value_length, run_last
//
// One input byte is taken per cycle while the bundle queue has room.
// The output register holds one result at a time; the four-entry queue
// absorbs the bursts of bytes that cause more than one result. A result is
// written to the queue and then loaded into the output register (out_valid).
// Synchronous reset restores the configuration and clears the query state.
// in_ready falls only when the queue is full; out_ready stalls the back part.
// ----------------------------------------------------------------------------
module query_parameter_extract_decode #(
  parameter int KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  query_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  value_byte,
  output logic        found,
  output logic [7:0]  value_length,
  output logic        run_last
);
  import qpx_pkg::*;

  logic    queue_full;
  logic    push;
  bundle_t push_data;
  logic    pop;
  logic    head_valid;
  bundle_t head_data;

  qpx_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .query_byte (query_byte),
    .final_byte (final_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  qpx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  qpx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .value_byte   (value_byte),
    .found        (found),
    .value_length (value_length),
    .run_last     (run_last)
  );

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_SUMMARY) |-> run_last)
    else $error("summary result not marked last");

  a_value_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_VALUE) |-> !found && (value_length == 8'd0))
    else $error("value result carries summary fields");

  a_not_found_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_SUMMARY) && !found |-> value_length == 8'd0)
    else $error("bytes emitted without a selected pair");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !in_ready)
    else $error("input taken while queue full");

endmodule
